// ===== rtl/core/sfah_pkg.sv =====
// shared types, constants and codes for the angle hold state feedback block
// no dependencies; imported by every other file of the block
package sfah_pkg;

  localparam int ANGLE_W   = 16;
  localparam int VEMF_W    = 16;
  localparam int TIME_W    = 20;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 64;
  // tau + dt after flooring fits in 21 bits
  localparam int DEN_W     = TIME_W + 1;
  localparam int CNT_W     = $clog2(WORD_W);
  localparam int CMD_W     = WORD_W + 17;

  localparam logic [TIME_W-1:0] TIME_FLOOR_US = 20'd100;
  localparam logic [TIME_W-1:0] TAU_RESET_US  = 20'd100000;
  localparam logic [20:0]       US_PER_S      = 21'd1000000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REF_TERM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ANGLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RATE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VEMF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TAU = 3'd6;

  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t MUL_TAU_RATE = 3'd0;
  localparam mul_sel_t MUL_DANGLE   = 3'd1;
  localparam mul_sel_t MUL_ANGLE    = 3'd2;
  localparam mul_sel_t MUL_RATE     = 3'd3;
  localparam mul_sel_t MUL_VEMF     = 3'd4;

  typedef logic [1:0] acc_op_t;
  localparam acc_op_t ACC_HOLD = 2'd0;
  localparam acc_op_t ACC_LOAD = 2'd1;
  localparam acc_op_t ACC_ADD  = 2'd2;

  typedef struct packed {
    logic signed [WORD_W-1:0] ref_term;
    logic signed [WORD_W-1:0] gain_angle;
    logic signed [WORD_W-1:0] gain_rate;
    logic signed [WORD_W-1:0] gain_vemf;
    logic signed [WORD_W-1:0] drive_min;
    logic signed [WORD_W-1:0] drive_max;
    logic [TIME_W-1:0]        filter_tau_us;
  } cfg_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     div_init;
    logic     div_step;
    logic     div_fin;
    logic     cmd_calc;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic primed;
    logic div_ovf;
  } dp_status_t;

endpackage

// ===== rtl/core/sfah_in_if.sv =====
// input channel: angle, back-emf and interval samples with valid/ready
// depends on sfah_pkg
interface sfah_in_if import sfah_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle_sample;
  logic signed [VEMF_W-1:0]  vemf_sample;
  logic [TIME_W-1:0]         interval_us;

  modport source (output valid, angle_sample, vemf_sample, interval_us, input ready);
  modport sink   (input valid, angle_sample, vemf_sample, interval_us, output ready);
endinterface

// ===== rtl/core/sfah_out_if.sv =====
// result channel: clamped drive command with valid/ready
// depends on sfah_pkg
interface sfah_out_if import sfah_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] drive_cmd;

  modport source (output valid, drive_cmd, input ready);
  modport sink   (input valid, drive_cmd, output ready);
endinterface

// ===== rtl/core/sfah_cfg_if.sv =====
// configuration write channel: register index and data with valid/ready
// depends on sfah_pkg
interface sfah_cfg_if import sfah_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sfah_cfg.sv =====
// configuration register file for the angle hold block
// depends on sfah_pkg and sfah_cfg_if
module sfah_cfg import sfah_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sfah_cfg_if.sink    cfg_ch,
  output cfg_t        cfg
);

  cfg_t              regs_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.ref_term      <= '0;
      regs_r.gain_angle    <= '0;
      regs_r.gain_rate     <= '0;
      regs_r.gain_vemf     <= '0;
      regs_r.drive_min     <= '0;
      regs_r.drive_max     <= '0;
      regs_r.filter_tau_us <= TAU_RESET_US;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_REF_TERM:   regs_r.ref_term      <= $signed(cfg_ch.data);
        REG_GAIN_ANGLE: regs_r.gain_angle    <= $signed(cfg_ch.data);
        REG_GAIN_RATE:  regs_r.gain_rate     <= $signed(cfg_ch.data);
        REG_GAIN_VEMF:  regs_r.gain_vemf     <= $signed(cfg_ch.data);
        REG_DRIVE_MIN:  regs_r.drive_min     <= $signed(cfg_ch.data);
        REG_DRIVE_MAX:  regs_r.drive_max     <= $signed(cfg_ch.data);
        REG_FILTER_TAU: regs_r.filter_tau_us <= cfg_ch.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // time constant leaves here already raised to the floor
  always_comb begin
    cfg = regs_r;
    if (regs_r.filter_tau_us < TIME_FLOOR_US) begin
      cfg.filter_tau_us = TIME_FLOOR_US;
    end
  end

endmodule

// ===== rtl/core/sfah_dp.sv =====
// datapath: shared 33x33 multiplier, accumulator, restoring divider, clamp
// depends on sfah_pkg; driven by sfah_ctrl through dp_cmd_t
module sfah_dp import sfah_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  input  logic signed [ANGLE_W-1:0] angle_in,
  input  logic signed [VEMF_W-1:0]  vemf_in,
  input  logic [TIME_W-1:0]         interval_in,
  output logic signed [WORD_W-1:0]  drive_cmd
);

  logic signed [ANGLE_W-1:0] angle_r;
  logic signed [ANGLE_W-1:0] last_angle_r;
  logic signed [VEMF_W-1:0]  vemf_r;
  logic signed [ANGLE_W:0]   dangle_r;
  logic [DEN_W-1:0]          den_r;
  logic                      primed_r;
  logic signed [WORD_W-1:0]  rate_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic                      neg_r;
  logic [DEN_W-1:0]          rem_r;
  logic [WORD_W-1:0]         quo_r;
  logic signed [CMD_W-1:0]   cmd_r;
  logic signed [WORD_W-1:0]  out_r;

  logic [TIME_W-1:0]         dt_floor;
  logic signed [WORD_W:0]    mul_a;
  logic signed [WORD_W:0]    mul_b;
  logic signed [2*WORD_W+1:0] mul_full;
  logic [PROD_W-1:0]         acc_abs;
  logic [DEN_W:0]            div_shift;
  logic [DEN_W+1:0]          div_diff;
  logic                      div_ge;
  logic signed [WORD_W-1:0]  rate_sat;
  logic signed [CMD_W-1:0]   lim_min;
  logic signed [CMD_W-1:0]   lim_max;
  logic signed [CMD_W-1:0]   cmd_lo;
  logic signed [CMD_W-1:0]   cmd_cl;
  logic signed [PROD_W-17:0] fb_shift;

  assign dt_floor = (interval_in < TIME_FLOOR_US) ? TIME_FLOOR_US : interval_in;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_TAU_RATE: begin
        mul_a = $signed({{(WORD_W+1-TIME_W){1'b0}}, cfg.filter_tau_us});
        mul_b = $signed({rate_r[WORD_W-1], rate_r});
      end
      MUL_DANGLE: begin
        mul_a = $signed({{(WORD_W-ANGLE_W){dangle_r[ANGLE_W]}}, dangle_r});
        mul_b = $signed({{(WORD_W+1-21){1'b0}}, US_PER_S});
      end
      MUL_ANGLE: begin
        mul_a = $signed({cfg.gain_angle[WORD_W-1], cfg.gain_angle});
        mul_b = $signed({{(WORD_W+1-ANGLE_W){angle_r[ANGLE_W-1]}}, angle_r});
      end
      MUL_RATE: begin
        mul_a = $signed({cfg.gain_rate[WORD_W-1], cfg.gain_rate});
        mul_b = $signed({rate_r[WORD_W-1], rate_r});
      end
      MUL_VEMF: begin
        mul_a = $signed({cfg.gain_vemf[WORD_W-1], cfg.gain_vemf});
        mul_b = $signed({{(WORD_W+1-VEMF_W){vemf_r[VEMF_W-1]}}, vemf_r});
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // magnitude of the filter numerator, quotient overflows 32 bits if high word >= den
  assign acc_abs  = acc_r[PROD_W-1] ? (~acc_r + 64'd1) : acc_r;
  assign status.div_ovf = (acc_abs[PROD_W-1:WORD_W] >= {{(WORD_W-DEN_W){1'b0}}, den_r});
  assign status.primed  = primed_r;

  assign div_shift = {rem_r, quo_r[WORD_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, den_r};
  assign div_ge    = !div_diff[DEN_W+1];

  // truncated quotient magnitude to saturated signed rate
  always_comb begin
    if (neg_r) begin
      if (quo_r > {1'b1, {(WORD_W-1){1'b0}}}) begin
        rate_sat = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
        rate_sat = $signed(~quo_r + 32'd1);
      end
    end else begin
      if (quo_r[WORD_W-1]) begin
        rate_sat = {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
        rate_sat = $signed(quo_r);
      end
    end
  end

  assign fb_shift = acc_r[PROD_W-1:16];
  assign lim_min  = $signed({{(CMD_W-WORD_W){cfg.drive_min[WORD_W-1]}}, cfg.drive_min});
  assign lim_max  = $signed({{(CMD_W-WORD_W){cfg.drive_max[WORD_W-1]}}, cfg.drive_max});
  assign cmd_lo   = (cmd_r < lim_min) ? lim_min : cmd_r;
  assign cmd_cl   = (cmd_lo > lim_max) ? lim_max : cmd_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r     <= 1'b0;
      last_angle_r <= '0;
      rate_r       <= '0;
    end else begin
      if (cmd.load_in) begin
        angle_r      <= angle_in;
        vemf_r       <= vemf_in;
        dangle_r     <= {angle_in[ANGLE_W-1], angle_in} - {last_angle_r[ANGLE_W-1], last_angle_r};
        den_r        <= {1'b0, cfg.filter_tau_us} + {1'b0, dt_floor};
        last_angle_r <= angle_in;
        primed_r     <= 1'b1;
        if (!primed_r) begin
          rate_r <= '0;
        end
      end
      if (cmd.mul_en) begin
        prod_r <= mul_full[PROD_W-1:0];
      end
      case (cmd.acc_op)
        ACC_LOAD: acc_r <= prod_r;
        ACC_ADD:  acc_r <= acc_r + prod_r;
        default: ;
      endcase
      if (cmd.div_init) begin
        neg_r <= acc_r[PROD_W-1];
        rem_r <= acc_abs[WORD_W+DEN_W-1:WORD_W];
        quo_r <= acc_abs[WORD_W-1:0];
        if (status.div_ovf) begin
          rate_r <= acc_r[PROD_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                    : {1'b0, {(WORD_W-1){1'b1}}};
        end
      end
      if (cmd.div_step) begin
        rem_r <= div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
        quo_r <= {quo_r[WORD_W-2:0], div_ge};
      end
      if (cmd.div_fin) begin
        rate_r <= rate_sat;
      end
      if (cmd.cmd_calc) begin
        cmd_r <= $signed({{(CMD_W-WORD_W){cfg.ref_term[WORD_W-1]}}, cfg.ref_term})
               - $signed({fb_shift[PROD_W-17], fb_shift});
      end
      if (cmd.out_load) begin
        out_r <= cmd_cl[WORD_W-1:0];
      end
    end
  end

  assign drive_cmd = out_r;

endmodule

// ===== rtl/core/sfah_ctrl.sv =====
// sequencer: steps the datapath through filter, division and feedback sum
// depends on sfah_pkg; drives sfah_dp through dp_cmd_t
module sfah_ctrl import sfah_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MA   = 4'd1;
  localparam logic [3:0] S_MB   = 4'd2;
  localparam logic [3:0] S_MC   = 4'd3;
  localparam logic [3:0] S_DCHK = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_DFIN = 4'd6;
  localparam logic [3:0] S_F0   = 4'd7;
  localparam logic [3:0] S_F1   = 4'd8;
  localparam logic [3:0] S_F2   = 4'd9;
  localparam logic [3:0] S_F3   = 4'd10;
  localparam logic [3:0] S_F4   = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mul_sel   = MUL_TAU_RATE;
    cmd.acc_op    = ACC_HOLD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          // first sample has no previous angle, rate starts at zero
          state_nxt   = status.primed ? S_MA : S_F0;
        end
      end
      S_MA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TAU_RATE;
        state_nxt   = S_MB;
      end
      S_MB: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DANGLE;
        state_nxt   = S_MC;
      end
      S_MC: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = S_DCHK;
      end
      S_DCHK: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = status.div_ovf ? S_F0 : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        cmd.div_fin = 1'b1;
        state_nxt   = S_F0;
      end
      S_F0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ANGLE;
        state_nxt   = S_F1;
      end
      S_F1: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RATE;
        state_nxt   = S_F2;
      end
      S_F2: begin
        cmd.acc_op  = ACC_ADD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VEMF;
        state_nxt   = S_F3;
      end
      S_F3: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = S_F4;
      end
      S_F4: begin
        cmd.cmd_calc = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        // wait here only while the previous word is still unclaimed
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/state_feedback_angle_hold.sv =====
// top level of the angle hold state feedback controller
// depends on sfah_pkg, the channel interfaces, sfah_cfg, sfah_dp and sfah_ctrl
//
// One drive command per input word. Each word updates a filtered rate estimate
// rate = (tau*rate + dangle*1e6) / (tau+dt), saturated to 32 bits, then forms
// ref_term - ((g_angle*angle + g_rate*rate + g_vemf*vemf) >>> 16) clamped to
// [drive_min, drive_max]. A new word is accepted only after the previous one has
// reached the output register; the 32-step restoring divider for the rate filter
// and the single shared 33x33 multiplier, used five times, do the work. A word
// whose quotient overflows 32 bits skips the divider; the first word after reset
// skips the whole rate filter. A finished word sits in the output register while
// the next input word is taken.
// Configuration is written through the cfg port, which is always ready; write
// it only while no word is in flight.
module state_feedback_angle_hold import sfah_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  sfah_in_if.sink  in_ch,
  sfah_out_if.source out_ch,
  sfah_cfg_if.sink cfg_ch
);

  cfg_t       cfg;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  sfah_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  sfah_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  sfah_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (dp_cmd),
    .status      (dp_status),
    .angle_in    (in_ch.angle_sample),
    .vemf_in     (in_ch.vemf_sample),
    .interval_in (in_ch.interval_us),
    .drive_cmd   (out_ch.drive_cmd)
  );

endmodule
